// File: rtl/core/ocp_pkg.sv
// Package for the orbit camera position block: constants, types, arctangent table.
// No dependencies.
package ocp_pkg;
  localparam int ANGLE_BITS_DEF = 16;
  localparam int TRIG_ITER_DEF  = 16;
  localparam int ATAN_DEPTH     = 24;
  localparam logic [9:0]  TURN_GAIN_RST = 10'd66;
  localparam logic [23:0] MIN_DIST_RST  = 24'd256;
  localparam logic [23:0] RADIUS_RST    = 24'd256;
  localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
  localparam logic [0:0] CFG_TURN_GAIN = 1'b0;
  localparam logic [0:0] CFG_MIN_DIST  = 1'b1;
  localparam logic OP_ORBIT = 1'b0;
  localparam logic OP_ZOOM  = 1'b1;

  typedef logic signed [33:0] trig_t;

  function automatic logic [31:0] atan_lookup(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0: v = 32'd536870912;  5'd1: v = 32'd316933406;
      5'd2: v = 32'd167458907;  5'd3: v = 32'd85004756;
      5'd4: v = 32'd42667331;   5'd5: v = 32'd21354465;
      5'd6: v = 32'd10679838;   5'd7: v = 32'd5340245;
      5'd8: v = 32'd2670163;    5'd9: v = 32'd1335087;
      5'd10: v = 32'd667544;    5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;    5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;     5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;     5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;       5'd21: v = 32'd326;
      5'd22: v = 32'd163;       5'd23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction
endpackage

// File: rtl/core/ocp_if.sv
// Valid/ready channel interfaces for the orbit camera block.
// No dependencies.
interface ocp_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic signed [10:0] move_x;
  logic signed [10:0] move_y;
  logic signed [15:0] zoom_delta;
  modport source (output valid, operation, move_x, move_y, zoom_delta, input ready);
  modport sink   (input valid, operation, move_x, move_y, zoom_delta, output ready);
endinterface

interface ocp_out_if;
  logic        valid;
  logic        ready;
  logic signed [24:0] pos_x;
  logic signed [24:0] pos_y;
  logic signed [24:0] pos_z;
  logic [15:0] horiz_angle;
  logic [15:0] vert_angle;
  logic [23:0] radius;
  modport source (output valid, pos_x, pos_y, pos_z, horiz_angle, vert_angle, radius,
                  input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, horiz_angle, vert_angle, radius,
                  output ready);
endinterface

interface ocp_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [23:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/ocp_cordic.sv
// Shared rotation unit: one CORDIC step per cycle, gives cos and sin in Q4.30.
// Depends on ocp_pkg.
module ocp_cordic #(
  parameter int ANGLE_BITS = ocp_pkg::ANGLE_BITS_DEF,
  parameter int TRIG_ITER  = ocp_pkg::TRIG_ITER_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [ANGLE_BITS-1:0] angle,
  output logic                  done,
  output ocp_pkg::trig_t        cos_q,
  output ocp_pkg::trig_t        sin_q
);
  import ocp_pkg::*;
  localparam int NSTEP = (TRIG_ITER < ATAN_DEPTH) ? TRIG_ITER : ATAN_DEPTH;

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [4:0]  i_r, i_nxt;
  logic [1:0]  quad_r, quad_nxt;
  trig_t       x_r, x_nxt, y_r, y_nxt;
  logic signed [32:0] z_r, z_nxt;
  logic [31:0] q32;

  assign q32 = 32'(angle) << (32 - ANGLE_BITS);

  always_comb begin
    busy_nxt = busy_r;
    i_nxt = i_r;
    quad_nxt = quad_r;
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
      i_nxt = 5'd0;
      quad_nxt = q32[31:30];
      x_nxt = GAIN_Q30;
      y_nxt = '0;
      z_nxt = {3'b000, q32[29:0]};
    end else if (busy_r) begin
      if (!z_r[32]) begin
        x_nxt = x_r - (y_r >>> i_r);
        y_nxt = y_r + (x_r >>> i_r);
        z_nxt = z_r - $signed({1'b0, atan_lookup(i_r)});
      end else begin
        x_nxt = x_r + (y_r >>> i_r);
        y_nxt = y_r - (x_r >>> i_r);
        z_nxt = z_r + $signed({1'b0, atan_lookup(i_r)});
      end
      i_nxt = i_r + 5'd1;
      if (i_r == 5'(NSTEP - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  assign done = done_r;

  always_comb begin
    case (quad_r)
      2'd0: begin cos_q = x_r;  sin_q = y_r;  end
      2'd1: begin cos_q = -y_r; sin_q = x_r;  end
      2'd2: begin cos_q = -x_r; sin_q = -y_r; end
      default: begin cos_q = y_r; sin_q = -x_r; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    i_r <= i_nxt;
    quad_r <= quad_nxt;
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end
endmodule

// File: rtl/core/orbit_camera_position.sv
// Orbit camera position: angle/distance update, then x, y, z from one shared CORDIC
// and one shared multiplier. After accept it runs the horizontal and then the vertical
// CORDIC pass, the multiplies for x, y and z, and loads the output register; in_ready
// is low from accept until it is back in idle, so no new beat is taken meanwhile.
// Synchronous active-low reset restores gain 66, minimum 256, angles 0, radius 256.
module orbit_camera_position #(
  parameter int ANGLE_BITS = ocp_pkg::ANGLE_BITS_DEF,
  parameter int TRIG_ITER  = ocp_pkg::TRIG_ITER_DEF
) (
  input  logic clk,
  input  logic rst_n,
  ocp_in_if.sink    in_ch,
  ocp_out_if.source out_ch,
  ocp_cfg_if.sink   cfg_ch
);
  import ocp_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001, S_TRH = 8'b00000010, S_WH = 8'b00000100,
    S_TRV  = 8'b00001000, S_WV = 8'b00010000, S_M1 = 8'b00100000,
    S_M2   = 8'b01000000, S_OUT = 8'b10000000
  } state_t;

  state_t state_r, state_nxt;
  logic [9:0]  gain_r;
  logic [23:0] mind_r, rad_r;
  logic [ANGLE_BITS-1:0] h_r, v_r;
  trig_t ch_r, sh_r, cv_r, sv_r;
  logic signed [34:0] rc_r;
  logic [1:0] mstep_r;
  logic signed [24:0] px_r, py_r, pz_r;
  logic ovalid_r;

  logic start;
  logic [ANGLE_BITS-1:0] tang;
  logic done;
  trig_t cq, sq;

  ocp_cordic #(.ANGLE_BITS(ANGLE_BITS), .TRIG_ITER(TRIG_ITER)) u_cordic (
    .clk, .rst_n, .start, .angle(tang), .done, .cos_q(cq), .sin_q(sq)
  );

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign start = (state_r == S_TRH) || (state_r == S_TRV);
  assign tang  = (state_r == S_TRH) ? h_r : v_r;

  // shared multiplier
  logic signed [34:0] ma;
  trig_t mb;
  logic signed [68:0] prod;
  logic signed [38:0] rnd;
  always_comb begin
    case (mstep_r)
      2'd0: begin ma = 35'(signed'({1'b0, rad_r})); mb = cv_r; end
      2'd1: begin ma = rc_r; mb = ch_r; end
      2'd2: begin ma = rc_r; mb = sh_r; end
      default: begin ma = 35'(signed'({1'b0, rad_r})); mb = sv_r; end
    endcase
    prod = ma * mb + 69'sd536870912;
    rnd = 39'(prod >>> 30);
  end

  function automatic logic signed [24:0] sat(input logic signed [38:0] v);
    if (v > 39'sd16777215) return 25'sd16777215;
    if (v < -39'sd16777216) return -25'sd16777216;
    return v[24:0];
  endfunction

  logic signed [ANGLE_BITS+12:0] dh, dv;
  logic signed [25:0] dsum;
  logic [23:0] rnew;
  always_comb begin
    dh = $signed({1'b0, gain_r}) * in_ch.move_x;
    dv = $signed({1'b0, gain_r}) * in_ch.move_y;
    dsum = $signed({2'b00, rad_r}) + 26'(in_ch.zoom_delta);
    if (dsum <= $signed({2'b00, mind_r})) rnew = mind_r;
    else if (dsum > 26'sd16777215) rnew = 24'hFFFFFF;
    else rnew = dsum[23:0];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_ch.valid) state_nxt = S_TRH;
      S_TRH:  state_nxt = S_WH;
      S_WH:   if (done) state_nxt = S_TRV;
      S_TRV:  state_nxt = S_WV;
      S_WV:   if (done) state_nxt = S_M1;
      S_M1:   state_nxt = S_M2;
      S_M2:   if (mstep_r == 2'd3) state_nxt = S_OUT;
      S_OUT:  if (!ovalid_r || out_ch.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      gain_r <= TURN_GAIN_RST;
      mind_r <= MIN_DIST_RST;
      rad_r <= RADIUS_RST;
      h_r <= '0;
      v_r <= '0;
      ovalid_r <= 1'b0;
      mstep_r <= 2'd0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          CFG_TURN_GAIN: gain_r <= cfg_ch.data[9:0];
          CFG_MIN_DIST:  mind_r <= cfg_ch.data;
          default: ;
        endcase
      end
      if (state_r == S_IDLE && in_ch.valid) begin
        if (in_ch.operation == OP_ORBIT) begin
          h_r <= h_r + dh[ANGLE_BITS-1:0];
          v_r <= v_r + dv[ANGLE_BITS-1:0];
        end else begin
          rad_r <= rnew;
        end
      end
      if (state_r == S_WH && done) begin ch_r <= cq; sh_r <= sq; end
      if (state_r == S_WV && done) begin cv_r <= cq; sv_r <= sq; mstep_r <= 2'd0; end
      if (state_r == S_M1) begin
        rc_r <= 35'(rnd);
        mstep_r <= 2'd1;
      end
      if (state_r == S_M2) begin
        case (mstep_r)
          2'd1: px_r <= sat(rnd);
          2'd2: py_r <= sat(rnd);
          default: pz_r <= sat(rnd);
        endcase
        mstep_r <= mstep_r + 2'd1;
      end
      if (state_r == S_OUT && (!ovalid_r || out_ch.ready)) ovalid_r <= 1'b1;
      else if (out_ch.ready) ovalid_r <= 1'b0;
    end
  end

  function automatic logic [15:0] a16(input logic [ANGLE_BITS-1:0] a);
    logic [39:0] w;
    w = 40'(a) << 16;
    return w[ANGLE_BITS+15 -: 16];
  endfunction

  logic [23:0] orad_r;
  logic [15:0] oh_r, ov_r;
  always_ff @(posedge clk) begin
    if (state_r == S_OUT && (!ovalid_r || out_ch.ready)) begin
      out_ch.pos_x <= px_r;
      out_ch.pos_y <= py_r;
      out_ch.pos_z <= pz_r;
      oh_r <= a16(h_r);
      ov_r <= a16(v_r);
      orad_r <= rad_r;
    end
  end
  assign out_ch.valid = ovalid_r;
  assign out_ch.horiz_angle = oh_r;
  assign out_ch.vert_angle = ov_r;
  assign out_ch.radius = orad_r;
endmodule

// File: rtl/core/ocp_checker.sv
// Port-level checks for orbit_camera_position, bound to the top level.
// Depends on ocp_if.
module ocp_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [23:0] radius
);
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready) else $error("accept while busy");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(radius)) else $error("radius changed");
  a_noout: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !$rose(out_valid)) else $error("early beat");
endmodule

bind orbit_camera_position ocp_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .radius(out_ch.radius)
);

// File: verif/tb.sv
// Testbench for orbit_camera_position: random and directed orbit/zoom beats with
// random stalls on the input and output channels, checked field by field against an in-bench predictor.
// Depends on ocp_pkg, ocp_if interfaces and the orbit_camera_position RTL.
module tb;
  import ocp_pkg::*;

  typedef struct {
    logic               op;
    logic signed [10:0] mx;
    logic signed [15:0] zd;
    logic signed [10:0] my;
  } cam_cmd_t;

  typedef struct {
    logic signed [24:0] px;
    logic signed [24:0] py;
    logic signed [24:0] pz;
    logic [15:0]        ha;
    logic [15:0]        va;
    logic [23:0]        rad;
  } cam_pos_t;

  class camera_scoreboard;
    logic [9:0]  gain;
    logic [23:0] min_dist;
    logic [15:0] h_turn;
    logic [15:0] v_turn;
    logic [23:0] cur_dist;
    cam_pos_t    pending[$];
    int          errors;

    function new();
      gain     = TURN_GAIN_RST;
      min_dist = MIN_DIST_RST;
      h_turn   = '0;
      v_turn   = '0;
      cur_dist = RADIUS_RST;
      errors   = 0;
    endfunction

    function void write_reg(logic [0:0] idx, logic [23:0] data);
      if (idx == CFG_TURN_GAIN) gain = data[9:0];
      else if (idx == CFG_MIN_DIST) min_dist = data;
    endfunction

    function void sin_cos(input logic [15:0] a, output longint c, output longint s);
      logic [31:0] q;
      longint      x, y, z, nx;
      q = {a, 16'h0};
      z = longint'(q[29:0]);
      x = longint'(GAIN_Q30);
      y = 0;
      for (int i = 0; i < 16; i++) begin
        if (z >= 0) begin
          nx = x - (y >>> i);
          y  = y + (x >>> i);
          z  = z - longint'(atan_lookup(5'(i)));
        end else begin
          nx = x + (y >>> i);
          y  = y - (x >>> i);
          z  = z + longint'(atan_lookup(5'(i)));
        end
        x = nx;
      end
      case (q[31:30])
        2'd0: begin c = x;  s = y;  end
        2'd1: begin c = -y; s = x;  end
        2'd2: begin c = -x; s = -y; end
        default: begin c = y; s = -x; end
      endcase
    endfunction

    function longint scale_q30(longint a, longint b);
      return (a * b + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function logic signed [24:0] sat25(longint v);
      if (v > 16777215) v = 16777215;
      if (v < -16777216) v = -16777216;
      return v[24:0];
    endfunction

    function void note_move(cam_cmd_t cmd);
      longint   step, d, ch, sh, cv, sv, rc;
      cam_pos_t e;
      if (cmd.op == OP_ORBIT) begin
        step   = longint'(gain) * longint'(cmd.mx);
        h_turn = h_turn + step[15:0];
        step   = longint'(gain) * longint'(cmd.my);
        v_turn = v_turn + step[15:0];
      end else begin
        d = longint'(cur_dist) + longint'(cmd.zd);
        if (d <= longint'(min_dist)) d = longint'(min_dist);
        if (d > 16777215) d = 16777215;
        cur_dist = d[23:0];
      end
      sin_cos(h_turn, ch, sh);
      sin_cos(v_turn, cv, sv);
      rc    = scale_q30(longint'(cur_dist), cv);
      e.px  = sat25(scale_q30(rc, ch));
      e.py  = sat25(scale_q30(rc, sh));
      e.pz  = sat25(scale_q30(longint'(cur_dist), sv));
      e.ha  = h_turn;
      e.va  = v_turn;
      e.rad = cur_dist;
      pending.push_back(e);
    endfunction

    function void check_pos(cam_pos_t got);
      cam_pos_t e;
      if (pending.size() == 0) begin
        $error("unexpected result beat");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.px !== e.px) begin $error("pos_x expected %0d got %0d", e.px, got.px); errors++; end
      if (got.py !== e.py) begin $error("pos_y expected %0d got %0d", e.py, got.py); errors++; end
      if (got.pz !== e.pz) begin $error("pos_z expected %0d got %0d", e.pz, got.pz); errors++; end
      if (got.ha !== e.ha) begin
        $error("horiz_angle expected %0d got %0d", e.ha, got.ha); errors++;
      end
      if (got.va !== e.va) begin
        $error("vert_angle expected %0d got %0d", e.va, got.va); errors++;
      end
      if (got.rad !== e.rad) begin
        $error("radius expected %0d got %0d", e.rad, got.rad); errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   in_burst;
  bit   out_burst;

  ocp_in_if  in_ch ();
  ocp_out_if out_ch ();
  ocp_cfg_if cfg_ch ();

  camera_scoreboard sb = new();

  orbit_camera_position i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("** orbit_camera_position: FAILED **");
    $finish;
  end

  always @(posedge clk) begin
    cam_pos_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.px  = out_ch.pos_x;
      got.py  = out_ch.pos_y;
      got.pz  = out_ch.pos_z;
      got.ha  = out_ch.horiz_angle;
      got.va  = out_ch.vert_angle;
      got.rad = out_ch.radius;
      sb.check_pos(got);
    end
  end

  function automatic int draw_gap(bit burst);
    return burst ? 0 : $urandom_range(0, 11);
  endfunction

  task automatic send_move(cam_cmd_t cmd);
    int gap;
    gap = draw_gap(in_burst);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.operation  <= cmd.op;
    in_ch.move_x     <= cmd.mx;
    in_ch.move_y     <= cmd.my;
    in_ch.zoom_delta <= cmd.zd;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_move(cmd);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [23:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.write_reg(idx, data);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic orbit(int mx, int my);
    cam_cmd_t c;
    c.op = OP_ORBIT;
    c.mx = 11'(mx);
    c.my = 11'(my);
    c.zd = 16'($urandom);
    send_move(c);
  endtask

  task automatic zoom(int zd);
    cam_cmd_t c;
    c.op = OP_ZOOM;
    c.mx = 11'($urandom);
    c.my = 11'($urandom);
    c.zd = 16'(zd);
    send_move(c);
  endtask

  task automatic random_moves(int n, int zoom_bias);
    cam_cmd_t c;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 63) == 0) in_burst = ~in_burst;
      c.op = ($urandom_range(0, 1) == 0) ? OP_ORBIT : OP_ZOOM;
      c.mx = 11'($urandom);
      c.my = 11'($urandom);
      c.zd = 16'($urandom);
      if (zoom_bias < 0 && c.zd > 0 && $urandom_range(0, 3) != 0) c.zd = -c.zd;
      if (zoom_bias > 0 && c.zd < 0 && $urandom_range(0, 3) != 0) c.zd = ~c.zd;
      send_move(c);
    end
  endtask

  initial begin
    forever begin
      int gap;
      if ($urandom_range(0, 63) == 0) out_burst = ~out_burst;
      gap = draw_gap(out_burst);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(rst_n && out_ch.valid));
    end
  end

  initial begin
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.operation    <= OP_ORBIT;
    in_ch.move_x       <= '0;
    in_ch.move_y       <= '0;
    in_ch.zoom_delta   <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= CFG_TURN_GAIN;
    cfg_ch.data        <= '0;
    in_burst  = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    orbit(0, 0);
    orbit(1023, -1024);
    orbit(-1024, 1023);
    orbit(500, 250);
    zoom(32767);
    zoom(-32768);
    zoom(-1);
    zoom(12000);
    orbit(-1, 1);
    drain();

    write_reg(CFG_TURN_GAIN, 24'd1023);
    write_reg(CFG_MIN_DIST, 24'd0);
    orbit(1023, 1023);
    orbit(-1024, -1024);
    orbit(64, -64);
    zoom(-32768);
    zoom(-32768);
    zoom(1);
    zoom(0);
    drain();

    write_reg(CFG_MIN_DIST, 24'd16777215);
    write_reg(CFG_TURN_GAIN, 24'd0);
    zoom(0);
    orbit(1023, -1024);
    drain();
    write_reg(CFG_TURN_GAIN, 24'd1);
    orbit(-1, 0);
    orbit(16384, 0);
    drain();
    write_reg(CFG_TURN_GAIN, 24'd16);
    orbit(1024 - 1, 1023);
    drain();
    write_reg(CFG_TURN_GAIN, 24'd0);
    write_reg(CFG_MIN_DIST, 24'd0);
    zoom(32767);
    drain();

    random_moves(250, 0);
    drain();
    write_reg(CFG_TURN_GAIN, 24'd1023);
    write_reg(CFG_MIN_DIST, 24'd0);
    random_moves(250, -1);
    drain();
    write_reg(CFG_TURN_GAIN, 24'd0);
    write_reg(CFG_MIN_DIST, 24'd16777215);
    random_moves(150, 0);
    drain();
    write_reg(CFG_MIN_DIST, 24'd16000000);
    write_reg(CFG_TURN_GAIN, 24'd1);
    random_moves(250, 1);
    drain();
    write_reg(CFG_TURN_GAIN, 24'($urandom_range(0, 1023)));
    write_reg(CFG_MIN_DIST, 24'($urandom_range(0, 4096)));
    random_moves(300, 0);
    drain();
    write_reg(CFG_TURN_GAIN, 24'($urandom_range(0, 1023)));
    write_reg(CFG_MIN_DIST, 24'($urandom));
    random_moves(300, 1);
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("** orbit_camera_position: PASSED **");
    end else begin
      $display("** orbit_camera_position: FAILED **");
    end
    $finish;
  end
endmodule
